// ===== hdl/iofx_pkg.sv =====
// ----------------------------------------------------------------------------
// iofx_pkg
// Shared types and constants of the four-neighbor outlier correction block.
// ----------------------------------------------------------------------------
package iofx_pkg;

    localparam int PIXEL_BITS    = 8;
    localparam int CFG_BITS      = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int ROW_LIMIT     = 1024;
    localparam int ROW_BITS      = 11;
    localparam int DEF_MAX_COLS  = 1024;
    localparam int DEF_Q_DEPTH   = 2;

    localparam logic [CFG_BITS-1:0] RST_FRAME_COLS = CFG_BITS'(30);
    localparam logic [CFG_BITS-1:0] RST_FRAME_ROWS = CFG_BITS'(20);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_COLS = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_ROWS = CFG_IDX_BITS'(1);

    // Input beat kinds.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [PIXEL_BITS-1:0] pixel_in;
    } t_in_beat;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  replaced;
        logic                  frame_end;
    } t_out_beat;

    // Work for the back end, classified by the front end.
    typedef struct packed {
        logic                  emit;      // a result is produced
        logic                  store;     // pixel is written to the center row
        logic                  has_up;
        logic                  has_down;
        logic                  has_left;
        logic                  has_right;
        logic                  last;      // final pixel of the frame
        logic [PIXEL_BITS-1:0] pixel;     // incoming (down) pixel
    } t_job;

endpackage

// ===== hdl/iofx_front.sv =====
// ----------------------------------------------------------------------------
// iofx_front
// Accepts beats, tracks the frame position and classifies each beat.
// ----------------------------------------------------------------------------
module iofx_front
    import iofx_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int CW       = $clog2(MAX_COLS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_beat                i_in_data,
    input  logic                    i_q_ready,
    output logic                    o_q_push,
    output logic [CW-1:0]           o_q_col,
    output t_job                    o_q_job
);

    localparam int CNTW = $clog2(MAX_COLS + 1);
    localparam int LW   = (CNTW > CFG_BITS) ? CNTW : CFG_BITS;

    logic [CFG_BITS-1:0] r_cfg_cols, r_cfg_rows;
    logic [CW-1:0]       r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;

    logic [LW-1:0]       cols_ext;
    logic [CNTW-1:0]     eff_cols;
    logic [ROW_BITS-1:0] eff_rows;
    logic [CNTW-1:0]     col_next;
    logic                row_end;
    logic                is_flush;
    logic                keep;
    logic                accept;
    logic                restart;

    always_comb begin
        cols_ext = LW'(r_cfg_cols);
        if (r_cfg_cols < CFG_BITS'(2)) begin
            eff_cols = CNTW'(2);
        end else if (cols_ext > LW'(MAX_COLS)) begin
            eff_cols = CNTW'(MAX_COLS);
        end else begin
            eff_cols = cols_ext[CNTW-1:0];
        end
        if (r_cfg_rows < CFG_BITS'(2)) begin
            eff_rows = ROW_BITS'(2);
        end else if (r_cfg_rows > CFG_BITS'(ROW_LIMIT)) begin
            eff_rows = ROW_BITS'(ROW_LIMIT);
        end else begin
            eff_rows = ROW_BITS'(r_cfg_rows);
        end
    end

    assign col_next = CNTW'(r_col) + CNTW'(1);
    assign row_end  = (col_next >= eff_cols);
    assign is_flush = (i_in_data.func == FUNC_FLUSH);
    assign keep     = is_flush ? (r_row == eff_rows) : (r_row < eff_rows);

    // Ignored beats are still taken, they just never reach the queue.
    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign o_q_push   = accept && keep;
    assign restart    = i_cfg_we &&
                        ((i_cfg_idx == REG_FRAME_COLS) || (i_cfg_idx == REG_FRAME_ROWS));

    always_comb begin
        o_q_col           = r_col;
        o_q_job.emit      = is_flush || (r_row != '0);
        o_q_job.store     = !is_flush;
        o_q_job.has_up    = is_flush || (r_row > ROW_BITS'(1));
        o_q_job.has_down  = !is_flush;
        o_q_job.has_left  = (r_col != '0);
        o_q_job.has_right = !row_end;
        o_q_job.last      = is_flush && row_end;
        o_q_job.pixel     = i_in_data.pixel_in;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_q_push) begin
            if (row_end) begin
                n_col = '0;
                n_row = is_flush ? '0 : r_row + ROW_BITS'(1);
            end else begin
                n_col = col_next[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= RST_FRAME_COLS;
            r_cfg_rows <= RST_FRAME_ROWS;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == REG_FRAME_COLS)) begin
                r_cfg_cols <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == REG_FRAME_ROWS)) begin
                r_cfg_rows <= i_cfg_data;
            end
            if (restart) begin
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

// ===== hdl/iofx_queue.sv =====
// ----------------------------------------------------------------------------
// iofx_queue
// Small register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module iofx_queue
    import iofx_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEF_Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_ready = (r_cnt != NW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(DEPTH))
        else $error("queue fill count out of range");

endmodule

// ===== hdl/iofx_back.sv =====
// ----------------------------------------------------------------------------
// iofx_back
// Holds the row stores, corrects one pixel per job and drives the output.
// ----------------------------------------------------------------------------
module iofx_back
    import iofx_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int CW       = $clog2(MAX_COLS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_pop,
    input  logic [CW-1:0] i_q_col,
    input  t_job          i_q_job,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out_beat     o_out_data
);

    localparam int SUM_BITS   = PIXEL_BITS + 2;
    localparam int DIV3_SHIFT = PIXEL_BITS + 3;
    localparam int PROD_BITS  = SUM_BITS + DIV3_SHIFT;
    localparam longint DIV3_MUL = ((longint'(1) << DIV3_SHIFT) + 2) / 3;

    localparam logic S_RD = 1'b0;
    localparam logic S_EX = 1'b1;

    logic [PIXEL_BITS-1:0] r_orig_row [MAX_COLS];
    logic [PIXEL_BITS-1:0] r_corr_row [MAX_COLS];

    logic                  r_state;
    t_job                  r_job;
    logic [CW-1:0]         r_col;
    logic [PIXEL_BITS-1:0] r_center, r_right, r_up, r_left;
    logic                  r_out_valid;
    t_out_beat             r_out;

    logic [CW-1:0]         rd_right_addr;
    logic                  ex_go;
    logic [2:0]            nb_cnt;
    logic [SUM_BITS-1:0]   sum, sum_p1, sum_p2;
    logic [PROD_BITS-1:0]  prod;
    logic                  all_far;
    logic [PIXEL_BITS-1:0] avg, result;

    function automatic logic far_from(input logic [PIXEL_BITS-1:0] a,
                                      input logic [PIXEL_BITS-1:0] b);
        logic [PIXEL_BITS-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d > PIXEL_BITS'(1);
    endfunction

    assign o_q_pop       = (r_state == S_RD) && i_q_valid;
    assign rd_right_addr = (i_q_col == CW'(MAX_COLS - 1)) ? '0 : i_q_col + CW'(1);

    // Neighbor average and the all-far test.
    always_comb begin
        nb_cnt = 3'(r_job.has_up) + 3'(r_job.has_down) + 3'(r_job.has_left)
               + 3'(r_job.has_right);
        sum = (r_job.has_up    ? SUM_BITS'(r_up)      : '0)
            + (r_job.has_down  ? SUM_BITS'(r_job.pixel) : '0)
            + (r_job.has_left  ? SUM_BITS'(r_left)    : '0)
            + (r_job.has_right ? SUM_BITS'(r_right)   : '0);
        all_far = (nb_cnt != '0);
        if (r_job.has_up && !far_from(r_center, r_up)) all_far = 1'b0;
        if (r_job.has_down && !far_from(r_center, r_job.pixel)) all_far = 1'b0;
        if (r_job.has_left && !far_from(r_center, r_left)) all_far = 1'b0;
        if (r_job.has_right && !far_from(r_center, r_right)) all_far = 1'b0;
        sum_p1 = sum + SUM_BITS'(1);
        sum_p2 = sum + SUM_BITS'(2);
        // Divide by three through a reciprocal multiply.
        prod   = PROD_BITS'(sum_p1) * PROD_BITS'(DIV3_MUL);
        case (nb_cnt)
            3'd2:    avg = sum_p1[PIXEL_BITS:1];
            3'd3:    avg = prod[DIV3_SHIFT +: PIXEL_BITS];
            3'd4:    avg = sum_p2[PIXEL_BITS+1:2];
            default: avg = r_center;
        endcase
        result = all_far ? avg : r_center;
    end

    assign ex_go = (r_state == S_EX) && (!r_job.emit || !r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_center <= r_orig_row[i_q_col];
            r_right  <= r_orig_row[rd_right_addr];
        end
        if (ex_go && r_job.store) begin
            r_orig_row[r_col] <= r_job.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_up <= r_corr_row[i_q_col];
        end
        if (ex_go && r_job.emit) begin
            r_corr_row[r_col] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
            r_col <= i_q_col;
        end
        if (ex_go && r_job.emit) begin
            r_out.pixel_out <= result;
            r_out.replaced  <= all_far;
            r_out.frame_end <= r_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RD;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            case (r_state)
                S_RD: begin
                    if (i_q_valid) r_state <= S_EX;
                end
                S_EX: begin
                    if (ex_go) r_state <= S_RD;
                end
                default: r_state <= S_RD;
            endcase
            if (ex_go && r_job.emit) begin
                r_left      <= result;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_stall_holds_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX && r_job.emit && r_out_valid && !i_out_ready)
        |=> (r_state == S_EX && $stable(r_job) && $stable(r_col)))
        else $error("job lost while output stalled");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_go && r_job.emit) |=> o_out_valid)
        else $error("emitted result not presented");

    a_last_is_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX && r_job.last) |-> (r_job.emit && !r_job.has_down && !r_job.store))
        else $error("frame end on a job that is not a final flush");

endmodule

// ===== hdl/image_outlier_neighbor_fix_unit.sv =====
// ----------------------------------------------------------------------------
// image_outlier_neighbor_fix_unit
// Four-neighbor impulse noise removal on a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Usage: pixel beats (func = pixel) enter on the i_in_* channel in raster
// order; after the last pixel of the frame the host sends frame_cols flush
// beats (func = flush) to drain the final row. Corrected pixels leave on the
// o_out_* channel one row behind the input; the beat that carries the last
// pixel of the frame has frame_end set. Row 0 pixels produce no output beat,
// and pixels past the frame end or early flushes are accepted and dropped.
// The back end works on one pixel at a time: it reads the row stores, then
// corrects the pixel and writes back, and takes no new job before it is
// through with the last. A result passes through the queue, the read step
// and the correct step into the output register. A two-entry queue
// separates the front end from the back end, so input is taken while a
// result waits in the output register. When the receiver stalls, the back
// end holds its job and input stops once the queue fills.
// Reset: frame size returns to 30 x 20 and the frame position to the start;
// the row stores are not cleared (every entry is written before its value
// is used). Any write to the column or row register restarts the frame.
// ----------------------------------------------------------------------------
module image_outlier_neighbor_fix_unit
    import iofx_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_beat                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_beat               o_out_data
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int QW  = CW + $bits(t_job);

    // Front end to queue.
    logic          q_push, q_ready;
    logic [CW-1:0] push_col;
    t_job          push_job;

    // Queue to back end.
    logic          q_valid, q_pop;
    logic [QW-1:0] q_head;
    logic [CW-1:0] head_col;
    t_job          head_job;

    iofx_front #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_col    (push_col),
        .o_q_job    (push_job)
    );

    // The queue stores the column together with the classified job.
    iofx_queue #(
        .WIDTH (QW),
        .DEPTH (DEF_Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({push_col, push_job}),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    assign head_col = q_head[QW-1 -: CW];
    assign head_job = t_job'(q_head[$bits(t_job)-1:0]);

    iofx_back #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_col     (head_col),
        .i_q_job     (head_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/sv/tb_image_outlier_neighbor_fix_unit.sv =====
// ----------------------------------------------------------------------------
// tb_image_outlier_neighbor_fix_unit
// Self-checking bench for the four-neighbor outlier correction block. A
// behavioral copy of the correction runs beside the design and predicts every
// output beat. The run covers part of a frame at reset size, a short table of
// hand-picked beats, short frames with the size registers at all ones, and
// then random frames with impulse noise, early flushes, extra pixels and
// abandoned frames.
// ----------------------------------------------------------------------------
module tb_image_outlier_neighbor_fix_unit;
    import iofx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 10;
    // Cycles allowed after the last expected beat for work that gives no beat.
    localparam int DRAIN_CYCLES = 16;
    // Cycles without any beat on either channel before the run is declared hung.
    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_BEATS = 380;
    // The last part of the random run goes with no idling at all.
    localparam int CALM_BEATS   = 300;
    // Pixels sent of the reset-size frame and of each frame at the largest sizes.
    localparam int RESET_PART   = 90;
    localparam int WIDE_PART    = 40;
    localparam int MAX_REPORTS  = 40;
    localparam int MIN_SIDE     = 2;
    localparam int PIX_MAX      = (1 << PIXEL_BITS) - 1;

    // Index that maps to no register; a write there must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(3);

    typedef enum logic {STEP_WRITE, STEP_BEAT} t_step_kind;

    // One row of the directed table: a register write or an input beat. A beat
    // row may carry its result typed in; all other rows use the predictor.
    typedef struct packed {
        t_step_kind              kind;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [CFG_BITS-1:0]     value;
        t_in_beat                beat;
        logic                    typed;
        t_out_beat               result;
    } t_plan_row;

    // The first frame is 2 x 2 (both sizes written below the minimum, so they
    // clamp): 0 255 / 255 0. The top left pixel is far from both its down and
    // right neighbors (255, 255) and becomes 255. The bottom right pixel sees
    // up 255 and left 255 and also becomes 255, with frame_end set. Flushes
    // before the frame is complete, extra pixels and a flush after the frame end
    // are all dropped. The second part restarts a 3 x 3 frame mid-way through
    // row 0 and then runs a frame with a spike in the middle.
    localparam t_plan_row PLAN [26] = '{
        '{STEP_WRITE, REG_FRAME_COLS, CFG_BITS'(0), '0, 1'b0, '0},
        '{STEP_WRITE, REG_FRAME_ROWS, CFG_BITS'(1), '0, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_FLUSH, 8'hA5}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd0}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd255}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd255}, 1'b1, '{8'd255, 1'b1, 1'b0}},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd0}, 1'b1, '{8'd255, 1'b0, 1'b0}},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd77}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_FLUSH, 8'h5A}, 1'b1, '{8'd255, 1'b0, 1'b0}},
        '{STEP_BEAT, '0, '0, '{FUNC_FLUSH, 8'hFF}, 1'b1, '{8'd255, 1'b1, 1'b1}},
        '{STEP_BEAT, '0, '0, '{FUNC_FLUSH, 8'h00}, 1'b0, '0},
        '{STEP_WRITE, REG_FRAME_COLS, CFG_BITS'(3), '0, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd200}, 1'b0, '0},
        '{STEP_WRITE, REG_FRAME_ROWS, CFG_BITS'(3), '0, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd10}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd20}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd10}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd20}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd100}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd21}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd10}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd20}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_PIXEL, 8'd11}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_FLUSH, 8'd0}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_FLUSH, 8'd0}, 1'b0, '0},
        '{STEP_BEAT, '0, '0, '{FUNC_FLUSH, 8'd0}, 1'b0, '0}
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [CFG_BITS-1:0]     cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    t_in_beat                in_beat;
    logic                    out_valid;
    logic                    out_ready;
    t_out_beat               out_beat;

    image_outlier_neighbor_fix_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_beat)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the frame geometry, the two row
    // stores and the position counters.
    // ------------------------------------------------------------------------
    logic [CFG_BITS-1:0]   cols_reg;
    logic [CFG_BITS-1:0]   rows_reg;
    logic [PIXEL_BITS-1:0] fixed_above [0:DEF_MAX_COLS-1]; // corrected row above
    logic [PIXEL_BITS-1:0] raw_center  [0:DEF_MAX_COLS-1]; // original row being fixed
    logic [PIXEL_BITS-1:0] fixed_left;
    int unsigned           next_col;
    int unsigned           next_row;
    logic [19:0]           out_count;
    int unsigned           taken_beats;   // input beats that were not dropped

    t_out_beat             pending_fixes [$];
    t_out_beat             want_beat;
    int                    mismatches;
    int                    quiet_cycles;
    int                    stall_left;
    int                    gap_odds;      // 0: no input gaps, else 1 in gap_odds+1
    int                    stall_odds;    // same for output stalls

    function automatic int unsigned live_cols();
        if (cols_reg < MIN_SIDE) return MIN_SIDE;
        if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
        return cols_reg;
    endfunction

    function automatic int unsigned live_rows();
        if (rows_reg < MIN_SIDE) return MIN_SIDE;
        if (rows_reg > ROW_LIMIT) return ROW_LIMIT;
        return rows_reg;
    endfunction

    function automatic void rewind_frame();
        fixed_left = '0;
        next_col   = 0;
        next_row   = 0;
        out_count  = '0;
    endfunction

    // Corrects the pixel at column c of the center row. The up and left
    // neighbors are corrected values, the down and right ones are originals.
    // The pixel is replaced only if every neighbor present is more than one
    // step away; the average then rounds halves up.
    function automatic t_out_beat correct_center(input int unsigned c, input bit has_up,
                                                 input bit has_down,
                                                 input logic [PIXEL_BITS-1:0] below);
        logic [PIXEL_BITS-1:0] centre;
        logic [PIXEL_BITS-1:0] nb [4];
        logic [PIXEL_BITS-1:0] val;
        int unsigned           n;
        int unsigned           sum;
        int unsigned           i;
        int                    d;
        bit                    all_far;
        t_out_beat             r;
        n       = 0;
        sum     = 0;
        all_far = 1'b1;
        centre  = raw_center[c];
        if (has_up) begin
            nb[n] = fixed_above[c];
            n++;
        end
        if (has_down) begin
            nb[n] = below;
            n++;
        end
        if (c > 0) begin
            nb[n] = fixed_left;
            n++;
        end
        if (c + 1 < live_cols()) begin
            nb[n] = raw_center[c + 1];
            n++;
        end
        for (i = 0; i < n; i++) begin
            sum += nb[i];
            d = int'(centre) - int'(nb[i]);
            if (d < 0) d = -d;
            if (d <= 1) all_far = 1'b0;
        end
        if (n == 0) all_far = 1'b0;
        val = all_far ? PIXEL_BITS'((sum + n / 2) / n) : centre;
        fixed_above[c] = val;
        fixed_left     = val;
        r.pixel_out = val;
        r.replaced  = all_far;
        r.frame_end = (out_count == 20'(live_rows() * live_cols() - 1));
        out_count++;
        return r;
    endfunction

    // Advances the predictor by one accepted input beat. Returns 1 when the
    // beat produces an output beat, which is then left in r.
    function automatic bit fix_beat(input t_in_beat b, output t_out_beat r);
        int unsigned cols;
        int unsigned rows;
        int unsigned c;
        bit          made;
        cols = live_cols();
        rows = live_rows();
        made = 1'b0;
        r    = '0;
        if (next_col >= cols) next_col = 0;
        c = next_col;
        if (b.func == FUNC_PIXEL) begin
            // Pixels past the frame end are dropped.
            if (next_row >= rows) return 1'b0;
            // Row 0 is only stored; each later pixel releases the one above it.
            if (next_row > 0) begin
                r    = correct_center(c, next_row > 1, 1'b1, b.pixel_in);
                made = 1'b1;
            end
            raw_center[c] = b.pixel_in;
            if (c + 1 >= cols) begin
                next_col = 0;
                next_row++;
            end else begin
                next_col = c + 1;
            end
        end else begin
            // A flush only counts once the whole frame is in.
            if (next_row != rows) return 1'b0;
            r    = correct_center(c, 1'b1, 1'b0, '0);
            made = 1'b1;
            if (c + 1 >= cols) rewind_frame();
            else next_col = c + 1;
        end
        taken_beats++;
        return made;
    endfunction

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Input side. Inputs change on the falling edge; a beat is taken at the
    // rising edge where valid and ready are both high. Valid is only lowered
    // before a gap or before a register write, so it is never dropped and
    // raised again within one time step.
    // ------------------------------------------------------------------------
    task automatic send_beat(input t_in_beat b, input bit typed = 1'b0,
                             input t_out_beat typed_res = '0);
        t_out_beat res;
        if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (fix_beat(b, res)) pending_fixes.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    // Stops input and waits until every expected beat is out, plus the time
    // the block may still spend on dropped beats, so a register write lands
    // while the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_fixes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        // Any write to a real register restarts the frame.
        if (idx == REG_FRAME_COLS) begin
            cols_reg = value;
            rewind_frame();
        end else if (idx == REG_FRAME_ROWS) begin
            rows_reg = value;
            rewind_frame();
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // A smooth background around a per-frame level with some wobble, broken
    // by impulses of random value or of full black or white.
    function automatic logic [PIXEL_BITS-1:0] scene_pixel(input int level, input int wobble);
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, PIX_MAX);
            1: v = ($urandom_range(0, 1) != 0) ? PIX_MAX : 0;
            default: v = level + int'($urandom_range(0, 2 * wobble)) - wobble;
        endcase
        if (v < 0) v = 0;
        if (v > PIX_MAX) v = PIX_MAX;
        return PIXEL_BITS'(v);
    endfunction

    // Sends one frame at the current size and drains it with flushes. A rough
    // frame may carry early flushes and extra pixels, or be abandoned part way.
    // A nonzero cut stops the frame after that many pixels.
    task automatic run_frame(input bit rough, input int unsigned cut, output bit lost);
        int unsigned cols;
        int unsigned total;
        int unsigned stop_at;
        int unsigned k;
        int          level;
        int          wobble;
        t_in_beat    b;
        cols    = live_cols();
        total   = cols * live_rows();
        level   = $urandom_range(0, PIX_MAX);
        wobble  = $urandom_range(1, 3);
        stop_at = (rough && $urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
        if (cut != 0 && cut < total) stop_at = cut;
        lost    = (stop_at != total);
        for (k = 0; k < stop_at; k++) begin
            if (rough && $urandom_range(0, 19) == 0) begin
                b.func     = FUNC_FLUSH;
                b.pixel_in = PIXEL_BITS'($urandom);
                send_beat(b);
            end
            b.func     = FUNC_PIXEL;
            b.pixel_in = scene_pixel(level, wobble);
            send_beat(b);
        end
        if (!lost) begin
            if (rough && $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    b.func     = FUNC_PIXEL;
                    b.pixel_in = PIXEL_BITS'($urandom);
                    send_beat(b);
                end
            end
            repeat (cols) begin
                b.func     = FUNC_FLUSH;
                b.pixel_in = PIXEL_BITS'($urandom);
                send_beat(b);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side. Ready is dropped in random bursts of random length.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
            stall_left = $urandom_range(0, 12);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Every output beat is matched against the oldest expectation, field by
    // field.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_fixes.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: output beat with nothing expected: %p", $time, out_beat);
                mismatches++;
            end else begin
                want_beat = pending_fixes.pop_front();
                if (out_beat.pixel_out !== want_beat.pixel_out) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: pixel_out expected %0d, got %0d", $time,
                                 want_beat.pixel_out, out_beat.pixel_out);
                    mismatches++;
                end
                if (out_beat.replaced !== want_beat.replaced) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: replaced expected %0b, got %0b", $time,
                                 want_beat.replaced, out_beat.replaced);
                    mismatches++;
                end
                if (out_beat.frame_end !== want_beat.frame_end) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: frame_end expected %0b, got %0b", $time,
                                 want_beat.frame_end, out_beat.frame_end);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a long stretch with no beat on either channel means a hang.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_image_outlier_neighbor_fix_unit failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : run
        bit          lost;
        int unsigned random_start;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_beat      = '0;
        out_ready    = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        stall_left   = 0;
        gap_odds     = 3;
        stall_odds   = 3;
        taken_beats  = 0;
        cols_reg     = RST_FRAME_COLS;
        rows_reg     = RST_FRAME_ROWS;
        rewind_frame();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The first rows of a frame at the size the block comes out of reset
        // with. The frame is left unfinished; the table starts with a write.
        run_frame(1'b0, RESET_PART, lost);

        // Directed table.
        foreach (PLAN[k]) begin
            if (PLAN[k].kind == STEP_WRITE) begin
                settle();
                write_reg(PLAN[k].idx, PLAN[k].value);
            end else begin
                send_beat(PLAN[k].beat, PLAN[k].typed, PLAN[k].result);
            end
        end

        // Largest sizes: both registers at all ones clamp to the maximum. Each
        // is paired with the smallest other side, and the frames are cut short.
        settle();
        write_reg(REG_FRAME_COLS, '1);
        write_reg(REG_FRAME_ROWS, CFG_BITS'(MIN_SIDE));
        run_frame(1'b0, WIDE_PART, lost);
        settle();
        write_reg(REG_FRAME_COLS, CFG_BITS'(MIN_SIDE));
        write_reg(REG_FRAME_ROWS, '1);
        run_frame(1'b0, WIDE_PART, lost);
        settle();
        write_reg(REG_FRAME_ROWS, CFG_BITS'(MIN_SIDE));

        // Random frames, mostly small. Sizes change between frames, sometimes
        // to below the minimum, and a frame left unfinished is always followed
        // by a register write.
        random_start = taken_beats;
        lost = 1'b1;
        while (taken_beats - random_start < RANDOM_BEATS) begin
            if (taken_beats - random_start >= CALM_BEATS) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else begin
                gap_odds   = $urandom_range(0, 2) * 3;
                stall_odds = $urandom_range(0, 2) * 3;
            end
            if (lost || $urandom_range(0, 2) == 0) begin
                settle();
                case ($urandom_range(0, 9))
                    0: write_reg(REG_SPARE, CFG_BITS'($urandom));
                    1: write_reg(REG_FRAME_COLS, CFG_BITS'($urandom_range(0, 1)));
                    2: write_reg(REG_FRAME_ROWS, CFG_BITS'($urandom_range(0, 1)));
                    3: write_reg(REG_FRAME_COLS, CFG_BITS'($urandom_range(9, 40)));
                    default: begin
                        write_reg(REG_FRAME_COLS, CFG_BITS'($urandom_range(2, 8)));
                        write_reg(REG_FRAME_ROWS, CFG_BITS'($urandom_range(2, 6)));
                    end
                endcase
            end
            run_frame(1'b1, 0, lost);
        end

        settle();
        if (mismatches == 0) begin
            $display("tb_image_outlier_neighbor_fix_unit passed");
        end else begin
            $display("tb_image_outlier_neighbor_fix_unit failed");
        end
        $finish;
    end

endmodule

// ===== image_outlier_neighbor_fix_unit.f =====
hdl/iofx_pkg.sv
hdl/iofx_front.sv
hdl/iofx_queue.sv
hdl/iofx_back.sv
hdl/image_outlier_neighbor_fix_unit.sv
tb/sv/tb_image_outlier_neighbor_fix_unit.sv
